// File: sv/scpe_pkg.sv
// shared types, codes and lookup functions for the screen code to petscii encoder
package scpe_pkg;

	// field widths
	localparam int unsigned CODE_W  = 8;
	localparam int unsigned COLOR_W = 4;
	localparam int unsigned REP_W   = 7;
	localparam int unsigned LC_W    = 5;

	// default row width and command queue depth
	localparam int unsigned MAX_WIDTH_DEF = 80;
	localparam int unsigned QUEUE_DEPTH   = 4;

	// petscii control bytes
	localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;
	localparam logic [CODE_W-1:0] CODE_REV_ON  = 8'd18;
	localparam logic [CODE_W-1:0] CODE_REV_OFF = 8'd146;
	localparam logic [CODE_W-1:0] CODE_CR      = 8'd13;
	localparam logic [LC_W-1:0]   COLOR_NONE   = 5'd16;

	// result slots of one cell, emitted in this order
	localparam int unsigned NSLOT          = 5;
	localparam int unsigned SLOT_FLUSH_OFF = 0;
	localparam int unsigned SLOT_RUN       = 1;
	localparam int unsigned SLOT_REV       = 2;
	localparam int unsigned SLOT_COLOR     = 3;
	localparam int unsigned SLOT_CHAR      = 4;

	// one classified cell: which slots fire, their bytes, and the space run length
	typedef struct packed {
		logic [NSLOT-1:0]             mask;
		logic [NSLOT-1:0][CODE_W-1:0] bytes;
		logic [REP_W-1:0]             run_len;
	} cmd_t;

	// color index to petscii color control byte
	function automatic logic [CODE_W-1:0] color_code(input logic [COLOR_W-1:0] color);
		logic [CODE_W-1:0] b;
		case (color)
			4'd0:    b = 8'h90;
			4'd1:    b = 8'h05;
			4'd2:    b = 8'h1c;
			4'd3:    b = 8'h9f;
			4'd4:    b = 8'h9c;
			4'd5:    b = 8'h1e;
			4'd6:    b = 8'h1f;
			4'd7:    b = 8'h9e;
			4'd8:    b = 8'h81;
			4'd9:    b = 8'h95;
			4'd10:   b = 8'h96;
			4'd11:   b = 8'h97;
			4'd12:   b = 8'h98;
			4'd13:   b = 8'h99;
			4'd14:   b = 8'h9a;
			default: b = 8'h9b;
		endcase
		return b;
	endfunction

	// screen code to petscii, remapped by 32-code quarter
	function automatic logic [CODE_W-1:0] map_char(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] c;
		logic [CODE_W-1:0] b;
		c = {1'b0, code[CODE_W-2:0]};
		case (c[6:5])
			2'd1:    b = c;
			2'd2:    b = c + 8'd128;
			default: b = c + 8'd64;
		endcase
		return b;
	endfunction

endpackage

// File: sv/scpe_front.sv
// front end: accepts cells, tracks reverse, color and held spaces, builds one command per cell
module scpe_front #(
	parameter int unsigned MAX_WIDTH = scpe_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [scpe_pkg::CODE_W-1:0]  screen_code,
	input  logic [scpe_pkg::COLOR_W-1:0] cell_color,
	input  logic                         row_end,
	input  logic                         add_cr,
	input  logic                         screen_start,
	input  logic                         q_full,
	output logic                         push,
	output scpe_pkg::cmd_t               push_cmd
);

	localparam int unsigned RW = scpe_pkg::REP_W;
	localparam logic [RW-1:0] MAX_PEND = RW'(MAX_WIDTH);

	logic [RW-1:0]                pending_q;
	logic [scpe_pkg::LC_W-1:0]    last_color_q;
	logic                         reverse_q;

	logic [RW-1:0]                pending_n;
	logic [scpe_pkg::LC_W-1:0]    last_color_n;
	logic                         reverse_n;
	logic                         rev_cur;
	logic [scpe_pkg::LC_W-1:0]    lc_cur;
	logic                         accept;
	scpe_pkg::cmd_t               cmd;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// classify the cell into result slots and next state
	always_comb begin
		rev_cur = screen_start ? 1'b0 : reverse_q;
		lc_cur  = screen_start ? scpe_pkg::COLOR_NONE : last_color_q;

		cmd          = '0;
		cmd.run_len  = pending_q;
		pending_n    = pending_q;
		last_color_n = lc_cur;
		reverse_n    = rev_cur;

		if (screen_code == scpe_pkg::CODE_SPACE) begin
			if (row_end) begin
				// trailing spaces dropped, reverse cleared silently
				pending_n = '0;
				reverse_n = 1'b0;
				if (add_cr) begin
					cmd.mask[scpe_pkg::SLOT_CHAR]  = 1'b1;
					cmd.bytes[scpe_pkg::SLOT_CHAR] = scpe_pkg::CODE_CR;
				end
			end else if (pending_q < MAX_PEND) begin
				pending_n = pending_q + RW'(1);
			end
		end else begin
			// flush held spaces, dropping reverse first
			if (pending_q != '0) begin
				if (reverse_n) begin
					cmd.mask[scpe_pkg::SLOT_FLUSH_OFF]  = 1'b1;
					cmd.bytes[scpe_pkg::SLOT_FLUSH_OFF] = scpe_pkg::CODE_REV_OFF;
					reverse_n = 1'b0;
				end
				cmd.mask[scpe_pkg::SLOT_RUN]  = 1'b1;
				cmd.bytes[scpe_pkg::SLOT_RUN] = scpe_pkg::CODE_SPACE;
				pending_n = '0;
			end
			// reverse video change
			if (screen_code[scpe_pkg::CODE_W-1] && !reverse_n) begin
				cmd.mask[scpe_pkg::SLOT_REV]  = 1'b1;
				cmd.bytes[scpe_pkg::SLOT_REV] = scpe_pkg::CODE_REV_ON;
				reverse_n = 1'b1;
			end else if (!screen_code[scpe_pkg::CODE_W-1] && reverse_n) begin
				cmd.mask[scpe_pkg::SLOT_REV]  = 1'b1;
				cmd.bytes[scpe_pkg::SLOT_REV] = scpe_pkg::CODE_REV_OFF;
				reverse_n = 1'b0;
			end
			// color change
			if (lc_cur != {1'b0, cell_color}) begin
				cmd.mask[scpe_pkg::SLOT_COLOR]  = 1'b1;
				cmd.bytes[scpe_pkg::SLOT_COLOR] = scpe_pkg::color_code(cell_color);
				last_color_n = {1'b0, cell_color};
			end
			cmd.mask[scpe_pkg::SLOT_CHAR]  = 1'b1;
			cmd.bytes[scpe_pkg::SLOT_CHAR] = scpe_pkg::map_char(screen_code);
		end
	end

	assign push     = accept && (cmd.mask != '0);
	assign push_cmd = cmd;

	// encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_color_q <= scpe_pkg::COLOR_NONE;
			reverse_q    <= 1'b0;
		end else if (accept) begin
			pending_q    <= pending_n;
			last_color_q <= last_color_n;
			reverse_q    <= reverse_n;
		end
	end

endmodule

// File: sv/scpe_queue.sv
// short command queue between the front and back ends
module scpe_queue #(
	parameter int unsigned DEPTH = scpe_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  scpe_pkg::cmd_t push_cmd,
	input  logic           pop,
	output scpe_pkg::cmd_t head,
	output logic           full,
	output logic           empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	scpe_pkg::cmd_t  entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: sv/scpe_back.sv
// back end: walks the slots of each command and sends one result per transfer
module scpe_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  scpe_pkg::cmd_t              head,
	input  logic                        q_empty,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scpe_pkg::CODE_W-1:0] out_byte,
	output logic [scpe_pkg::REP_W-1:0]  repeat_res,
	output logic                        run_last
);

	localparam int unsigned NS = scpe_pkg::NSLOT;
	localparam int unsigned RW = scpe_pkg::REP_W;

	logic [NS-1:0]                        mask_q;
	logic [NS-1:0][scpe_pkg::CODE_W-1:0]  bytes_q;
	logic [RW-1:0]                        run_len_q;

	logic                        out_valid_q;
	logic [scpe_pkg::CODE_W-1:0] out_byte_q;
	logic [RW-1:0]               repeat_q;
	logic                        run_last_q;

	logic [NS-1:0]               low;
	logic [NS-1:0]               rest;
	logic [scpe_pkg::CODE_W-1:0] sel_byte;
	logic [RW-1:0]               sel_rep;
	logic                        out_free;
	logic                        emit;

	// lowest pending slot
	always_comb begin
		low      = mask_q & (~mask_q + NS'(1));
		rest     = mask_q & ~low;
		sel_byte = '0;
		for (int i = 0; i < NS; i++) begin
			if (low[i]) begin
				sel_byte = bytes_q[i];
			end
		end
		sel_rep = low[scpe_pkg::SLOT_RUN] ? run_len_q : RW'(1);
	end

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = out_free && (mask_q != '0);
	assign pop      = !q_empty && ((mask_q == '0) || (emit && (rest == '0)));

	// current command slot mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= head.mask;
		end else if (emit) begin
			mask_q <= rest;
		end
	end

	// current command payload
	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q   <= head.bytes;
			run_len_q <= head.run_len;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= sel_byte;
			repeat_q   <= sel_rep;
			run_last_q <= (rest == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign repeat_res = repeat_q;
	assign run_last   = run_last_q;

endmodule

// File: sv/screen_code_to_petscii_encoder.sv
// top level of the screen code to petscii encoder
//
// Input channel: one screen cell per transfer (in_valid / in_stall) with its
// screen code, color, row end mark, add-CR flag and screen start flag.
// Output channel: petscii results (out_valid / out_stall), each a byte and a
// repeat count; run_last marks the last result that a cell causes.
// A cell causes zero to five results. The front end classifies a cell in the
// cycle it is accepted and pushes a command into a four-entry queue; the back
// end sends one result per cycle from its output register while the receiver
// does not stall. With the queue empty, the first result of a cell passes
// through a queue entry, the back end slot mask and the output register.
// One cell per cycle may be accepted while the queue is not full; a cell with
// no result pushes no command.
// in_stall rises only when the queue is full. When the receiver stalls, the
// output result holds and the queue fills behind it.
// Reset clears held spaces and reverse video, sets the last color to none and
// empties the queue and output register.
module screen_code_to_petscii_encoder #(
	parameter int unsigned MAX_WIDTH   = scpe_pkg::MAX_WIDTH_DEF,
	parameter int unsigned QUEUE_DEPTH = scpe_pkg::QUEUE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [scpe_pkg::CODE_W-1:0]  screen_code,
	input  logic [scpe_pkg::COLOR_W-1:0] cell_color,
	input  logic                         row_end,
	input  logic                         add_cr,
	input  logic                         screen_start,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [scpe_pkg::CODE_W-1:0]  out_byte,
	output logic [scpe_pkg::REP_W-1:0]   repeat_res,
	output logic                         run_last
);

	logic           q_full;
	logic           q_empty;
	logic           push;
	logic           pop;
	scpe_pkg::cmd_t push_cmd;
	scpe_pkg::cmd_t head;

	// classify cells
	scpe_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.screen_code (screen_code),
		.cell_color  (cell_color),
		.row_end     (row_end),
		.add_cr      (add_cr),
		.screen_start(screen_start),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// decouple front and back
	scpe_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	// emit results
	scpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.repeat_res(repeat_res),
		.run_last  (run_last)
	);

endmodule

// File: sv/scpe_checker.sv
// port checker for the screen code to petscii encoder, bound to the top level
module scpe_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [scpe_pkg::CODE_W-1:0] out_byte,
	input logic [scpe_pkg::REP_W-1:0]  repeat_res,
	input logic                        run_last
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(repeat_res)
			&& $stable(run_last))
		else $error("result changed while stalled");

	// only a space run repeats, and never with a zero count
	a_rep_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (repeat_res == 7'd1)
			|| (out_byte == scpe_pkg::CODE_SPACE && repeat_res != 7'd0))
		else $error("repeat count on a non-space result");

	// a space run repeated more than once is never the last result of its cell
	a_run_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && repeat_res > 7'd1 |-> !run_last)
		else $error("space run marked as last result of a cell");

	// carriage return ends its cell
	a_cr_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == scpe_pkg::CODE_CR |-> run_last)
		else $error("carriage return not last result of a cell");

endmodule

bind screen_code_to_petscii_encoder scpe_checker u_scpe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.repeat_res(repeat_res),
	.run_last  (run_last)
);

// File: bench/testbench.sv
// self-checking testbench for the screen code to petscii encoder
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import scpe_pkg::*;

	localparam int unsigned ROW_LIMIT   = MAX_WIDTH_DEF;
	localparam int unsigned PHASE_CELLS = 148;
	localparam logic [CODE_W-1:0] REV_SPACE = 8'd160;

	// petscii color control byte for each color index
	localparam logic [CODE_W-1:0] COLOR_CTRL [16] = '{
		8'h90, 8'h05, 8'h1c, 8'h9f, 8'h9c, 8'h1e, 8'h1f, 8'h9e,
		8'h81, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'h9b
	};

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COLOR_W-1:0] color;
		logic               row_end;
		logic               add_cr;
		logic               start;
	} cell_t;

	typedef struct packed {
		logic [CODE_W-1:0] pbyte;
		logic [REP_W-1:0]  rep;
		logic              last;
	} petscii_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [CODE_W-1:0] screen_code = '0;
	logic [COLOR_W-1:0] cell_color = '0;
	logic row_end = 1'b0;
	logic add_cr = 1'b0;
	logic screen_start = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CODE_W-1:0] out_byte;
	logic [REP_W-1:0] repeat_res;
	logic run_last;

	cell_t cell_queue[$];
	petscii_t petscii_expected[$];
	int cells_added = 0;
	int mismatch_count = 0;
	int result_index = 0;
	int send_idle_pct = 7;
	int recv_idle_pct = 80;

	// encoder state as the predictor tracks it
	logic [REP_W-1:0] held_spaces = '0;
	logic [LC_W-1:0]  sent_color = COLOR_NONE;
	logic             reverse_video = 1'b0;

	screen_code_to_petscii_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.screen_code  (screen_code),
		.cell_color   (cell_color),
		.row_end      (row_end),
		.add_cr       (add_cr),
		.screen_start (screen_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.repeat_res   (repeat_res),
		.run_last     (run_last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 100) $display("MISMATCH: %s", msg);
	endtask

	task automatic add_cell(input logic [CODE_W-1:0] code, input logic [COLOR_W-1:0] color,
			input logic re, input logic cr, input logic st);
		cell_queue.push_back('{code: code, color: color, row_end: re, add_cr: cr, start: st});
		cells_added++;
	endtask

	function automatic logic [CODE_W-1:0] petscii_char(input logic [CODE_W-1:0] code);
		logic [CODE_W-1:0] low7;
		low7 = {1'b0, code[6:0]};
		case (low7[6:5])
			2'd1:    return low7;
			2'd2:    return low7 + 8'd128;
			default: return low7 + 8'd64;
		endcase
	endfunction

	task automatic put_petscii(input logic [CODE_W-1:0] b, input logic [REP_W-1:0] n);
		petscii_expected.push_back('{pbyte: b, rep: n, last: 1'b0});
	endtask

	// work out the results that one accepted cell causes
	task automatic encode_cell(input cell_t c);
		int produced;
		produced = petscii_expected.size();
		if (c.start) begin
			reverse_video = 1'b0;
			sent_color = COLOR_NONE;
		end
		if (c.code == CODE_SPACE) begin
			if (c.row_end) begin
				// trailing blanks dropped, reverse cleared silently
				held_spaces = '0;
				if (c.add_cr) put_petscii(CODE_CR, 7'd1);
				reverse_video = 1'b0;
			end else if (int'(held_spaces) < ROW_LIMIT) begin
				held_spaces = held_spaces + 7'd1;
			end
		end else begin
			// flush the held space run
			if (held_spaces != '0) begin
				if (reverse_video) begin
					put_petscii(CODE_REV_OFF, 7'd1);
					reverse_video = 1'b0;
				end
				put_petscii(CODE_SPACE, held_spaces);
				held_spaces = '0;
			end
			if (c.code[7] && !reverse_video) begin
				put_petscii(CODE_REV_ON, 7'd1);
				reverse_video = 1'b1;
			end else if (!c.code[7] && reverse_video) begin
				put_petscii(CODE_REV_OFF, 7'd1);
				reverse_video = 1'b0;
			end
			if (sent_color != {1'b0, c.color}) begin
				sent_color = {1'b0, c.color};
				put_petscii(COLOR_CTRL[c.color], 7'd1);
			end
			put_petscii(petscii_char(c.code), 7'd1);
		end
		if (petscii_expected.size() > produced)
			petscii_expected[petscii_expected.size()-1].last = 1'b1;
	endtask

	// one row of random cells: mostly well formed, some long blank runs, some noise
	task automatic gen_row();
		int kind;
		int width;
		int pick;
		logic [COLOR_W-1:0] row_color;
		logic [CODE_W-1:0] code;
		logic [COLOR_W-1:0] color;
		logic is_last;
		kind = int'($urandom_range(0, 15));
		row_color = COLOR_W'($urandom_range(0, 15));
		if (kind == 0) begin
			// blank run of 78 to 90 cells, around the limit of the held count
			width = int'($urandom_range(78, 90));
			for (int i = 0; i < width; i++)
				add_cell(CODE_SPACE, row_color, 1'b0, 1'b0, (i == 0) && ($urandom_range(0, 1) == 1));
			code = CODE_W'($urandom_range(0, 255));
			if (code == CODE_SPACE) code = 8'd33;
			add_cell(code, row_color, 1'b1, 1'($urandom_range(0, 1)), 1'b0);
		end else if (kind <= 2) begin
			width = int'($urandom_range(1, 12));
			for (int i = 0; i < width; i++)
				add_cell(CODE_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 15)),
					$urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
					$urandom_range(0, 3) == 0);
		end else begin
			width = int'($urandom_range(1, 16));
			for (int i = 0; i < width; i++) begin
				is_last = (i == width - 1);
				pick = int'($urandom_range(0, 99));
				if (pick < 40 || (is_last && pick < 70)) code = CODE_SPACE;
				else if (pick < 50) code = REV_SPACE;
				else code = CODE_W'($urandom_range(0, 255));
				color = ($urandom_range(0, 9) < 7) ? row_color : COLOR_W'($urandom_range(0, 15));
				add_cell(code, color, is_last, is_last && ($urandom_range(0, 1) == 1),
					(i == 0) && ($urandom_range(0, 4) == 0));
			end
		end
	endtask

	task automatic wait_drained();
		while (cell_queue.size() != 0 || in_valid || petscii_expected.size() != 0)
			@(posedge clk);
	endtask

	// input driver: a payload is held while stalled, otherwise the next cell or a gap
	always @(posedge clk) begin
		cell_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				encode_cell('{code: screen_code, color: cell_color, row_end: row_end,
					add_cr: add_cr, start: screen_start});
			if (!in_valid || !in_stall) begin
				if (cell_queue.size() != 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
					nxt = cell_queue.pop_front();
					screen_code  <= nxt.code;
					cell_color   <= nxt.color;
					row_end      <= nxt.row_end;
					add_cr       <= nxt.add_cr;
					screen_start <= nxt.start;
					in_valid     <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each transfer with the oldest expectation
	always @(posedge clk) begin
		petscii_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (petscii_expected.size() == 0) begin
					report_mismatch($sformatf("result %0d: byte %0h with nothing expected",
						result_index, out_byte));
				end else begin
					want = petscii_expected.pop_front();
					if (out_byte !== want.pbyte)
						report_mismatch($sformatf("result %0d: out_byte %0h, expected %0h",
							result_index, out_byte, want.pbyte));
					if (repeat_res !== want.rep)
						report_mismatch($sformatf("result %0d: repeat_res %0d, expected %0d",
							result_index, repeat_res, want.rep));
					if (run_last !== want.last)
						report_mismatch($sformatf("result %0d: run_last %0b, expected %0b",
							result_index, run_last, want.last));
				end
				result_index++;
			end
			out_stall <= (int'($urandom_range(0, 99)) < recv_idle_pct);
		end
	end

	// stimulus and end of run
	initial begin
		int target;
		int guard;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every quarter of the map, colors, reverse changes
		add_cell(8'd1,   4'd1,  1'b0, 1'b0, 1'b1);
		add_cell(8'd0,   4'd1,  1'b0, 1'b0, 1'b0);
		add_cell(8'd31,  4'd1,  1'b0, 1'b0, 1'b0);
		add_cell(8'd63,  4'd2,  1'b0, 1'b0, 1'b0);
		add_cell(8'd64,  4'd2,  1'b0, 1'b0, 1'b0);
		add_cell(8'd95,  4'd2,  1'b0, 1'b0, 1'b0);
		add_cell(8'd96,  4'd2,  1'b0, 1'b0, 1'b0);
		add_cell(8'd127, 4'd0,  1'b0, 1'b0, 1'b0);
		add_cell(8'd128, 4'd0,  1'b0, 1'b0, 1'b0);
		add_cell(8'd255, 4'd15, 1'b0, 1'b0, 1'b0);
		// space run flushed while reverse is on, then reverse on again: five results
		add_cell(CODE_SPACE, 4'd15, 1'b0, 1'b0, 1'b0);
		add_cell(8'd130, 4'd3,  1'b0, 1'b0, 1'b0);
		// space run flushed with reverse on, plain cell after
		add_cell(CODE_SPACE, 4'd3, 1'b0, 1'b0, 1'b0);
		add_cell(CODE_SPACE, 4'd3, 1'b0, 1'b0, 1'b0);
		add_cell(8'd65,  4'd3,  1'b0, 1'b0, 1'b0);
		// row ending in a space, with and without carriage return
		add_cell(CODE_SPACE, 4'd3, 1'b1, 1'b1, 1'b0);
		add_cell(8'd140, 4'd3,  1'b0, 1'b0, 1'b0);
		add_cell(CODE_SPACE, 4'd3, 1'b0, 1'b0, 1'b0);
		add_cell(CODE_SPACE, 4'd3, 1'b1, 1'b0, 1'b0);
		add_cell(8'd10,  4'd3,  1'b0, 1'b0, 1'b0);
		// row ending in a character keeps reverse video
		add_cell(8'd150, 4'd3,  1'b1, 1'b1, 1'b0);
		add_cell(8'd151, 4'd3,  1'b0, 1'b0, 1'b0);
		// held spaces survive a screen start
		add_cell(CODE_SPACE, 4'd3, 1'b0, 1'b0, 1'b0);
		add_cell(CODE_SPACE, 4'd3, 1'b0, 1'b0, 1'b0);
		add_cell(8'd5,   4'd3,  1'b0, 1'b0, 1'b1);
		add_cell(REV_SPACE, 4'd3, 1'b0, 1'b0, 1'b0);

		// three idle phases: slow receiver, slow sender, no idling
		for (int phase = 0; phase < 3; phase++) begin
			target = cells_added + PHASE_CELLS;
			while (cells_added < target) gen_row();
			wait_drained();
			@(posedge clk);
			send_idle_pct <= (phase == 0) ? 80 : 0;
			recv_idle_pct <= (phase == 0) ? 7 : 0;
		end

		guard = 0;
		while (petscii_expected.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (10) @(posedge clk);
		if (petscii_expected.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				petscii_expected.size()));

		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// watchdog
	initial begin
		#3000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
